FILE: hw/rtl/spd_pkg.sv
package spd_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int KEY_BITS   = 2 * COORD_BITS + 2;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 3);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic                         last_point;
  } pt_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sorted_x;
    logic signed [COORD_BITS-1:0] sorted_y;
    logic                         end_of_list;
    logic                         truncated;
  } pt_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [KEY_BITS-1:0]          key;
  } cell_data_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic sort;
    logic phase;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_KEY  = 4'b0010,
    ST_SORT = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

endpackage

FILE: hw/rtl/sort_points_by_distance_from_corner.sv
// Channel  | Ports                  | Handshake
// ---------+------------------------+-------------------------------------------
// input    | start, busy, in_data   | beat taken when start && !busy
// result   | out_valid, out_data    | one-cycle strobe, receiver cannot stall
//
// Points load one per cycle into the cell row while busy is low. The closing
// point starts the work: rotating the row through the single key unit, then
// odd-even transposition passes, then one result per cycle for each stored
// point. busy is high from the closing point until the final result beat.
// Reset clears the count, reference and overflow flag.
module sort_points_by_distance_from_corner (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  spd_pkg::pt_in_t  in_data,
  output logic             out_valid,
  output spd_pkg::pt_out_t out_data
);

  localparam int N  = spd_pkg::MAX_POINTS;
  localparam int CW = spd_pkg::COORD_BITS;
  localparam int NB = spd_pkg::CNT_BITS;
  localparam int IB = spd_pkg::IDX_BITS;

  spd_pkg::state_t state_r, state_nxt;
  logic [NB-1:0]   count_r, count_nxt;
  logic [NB-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic signed [CW-1:0] ref_x_r, ref_x_nxt, ref_y_r, ref_y_nxt;
  logic            out_vld_r, out_vld_nxt;
  spd_pkg::pt_out_t out_r, out_nxt;

  logic accept;
  logic full;
  logic cnt_end_key, cnt_end_sort, out_last;
  spd_pkg::cell_ctl_t  ctl;
  spd_pkg::cell_data_t cell_q [N];
  spd_pkg::cell_data_t key_q;
  logic [N-1:0] occ;
  logic [N-1:0] ld_en;

  assign busy         = (state_r != spd_pkg::ST_LOAD);
  assign accept       = start && !busy;
  assign full         = (count_r == NB'(N));
  assign cnt_end_key  = (cnt_r == NB'(N + 1));
  assign cnt_end_sort = (cnt_r == NB'(N - 1));
  assign out_last     = (cnt_r == count_r - 1'b1);

  always_comb begin
    ctl.load  = accept && !full;
    ctl.shift = (state_r == spd_pkg::ST_KEY) || (state_r == spd_pkg::ST_OUT);
    ctl.sort  = (state_r == spd_pkg::ST_SORT);
    ctl.phase = cnt_r[0];
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    ref_x_nxt   = ref_x_r;
    ref_y_nxt   = ref_y_r;
    out_vld_nxt = 1'b0;
    out_nxt     = out_r;
    unique case (state_r)
      spd_pkg::ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            if ((count_r == '0) || (in_data.x_coord < ref_x_r) ||
                ((in_data.x_coord == ref_x_r) && (in_data.y_coord < ref_y_r))) begin
              ref_x_nxt = in_data.x_coord;
              ref_y_nxt = in_data.y_coord;
            end
            count_nxt = count_r + 1'b1;
          end
          if (in_data.last_point) begin
            state_nxt = spd_pkg::ST_KEY;
            cnt_nxt   = '0;
          end
        end
      end
      spd_pkg::ST_KEY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_end_key) begin
          state_nxt = spd_pkg::ST_SORT;
          cnt_nxt   = '0;
        end
      end
      spd_pkg::ST_SORT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_end_sort) begin
          state_nxt = spd_pkg::ST_OUT;
          cnt_nxt   = '0;
        end
      end
      spd_pkg::ST_OUT: begin
        out_vld_nxt          = 1'b1;
        out_nxt.sorted_x     = cell_q[0].x;
        out_nxt.sorted_y     = cell_q[0].y;
        out_nxt.end_of_list  = out_last;
        out_nxt.truncated    = ovf_r;
        cnt_nxt              = cnt_r + 1'b1;
        if (out_last) begin
          state_nxt = spd_pkg::ST_LOAD;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = spd_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= spd_pkg::ST_LOAD;
      count_r   <= '0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      ref_x_r   <= '0;
      ref_y_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      ref_x_r   <= ref_x_nxt;
      ref_y_r   <= ref_y_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // closes the rotation ring: cell 0 feeds it, the last cell takes its output
  spd_key u_key (
    .clk     (clk),
    .en_i    (state_r == spd_pkg::ST_KEY),
    .ref_x_i (ref_x_r),
    .ref_y_i (ref_y_r),
    .dat_i   (cell_q[0]),
    .dat_o   (key_q)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    spd_pkg::cell_data_t left_d, right_d;
    logic occ_r_bit;

    assign occ[i]   = (NB'(i) < count_r);
    assign ld_en[i] = (count_r[IB-1:0] == IB'(i));

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_d   = key_q;
      assign occ_r_bit = 1'b0;
    end else begin : g_mid_r
      assign right_d   = cell_q[i+1];
      assign occ_r_bit = occ[i+1];
    end

    spd_cell u_cell (
      .clk         (clk),
      .ctl_i       (ctl),
      .ld_en_i     (ld_en[i]),
      .ld_pt_i     (in_data),
      .odd_i       (1'(i % 2)),
      .occ_self_i  (occ[i]),
      .occ_right_i (occ_r_bit),
      .left_i      (left_d),
      .right_i     (right_d),
      .dat_o       (cell_q[i])
    );
  end

endmodule

FILE: hw/rtl/spd_cell.sv
module spd_cell (
  input  logic               clk,
  input  spd_pkg::cell_ctl_t ctl_i,
  input  logic               ld_en_i,
  input  spd_pkg::pt_in_t    ld_pt_i,
  input  logic               odd_i,
  input  logic               occ_self_i,
  input  logic               occ_right_i,
  input  spd_pkg::cell_data_t left_i,
  input  spd_pkg::cell_data_t right_i,
  output spd_pkg::cell_data_t dat_o
);

  spd_pkg::cell_data_t dat_r, dat_nxt;
  logic is_left;
  logic swap_l;
  logic swap_r;

  // strict compare keeps equal keys in arrival order
  assign is_left = (odd_i == ctl_i.phase);
  assign swap_l  = occ_right_i && (dat_r.key > right_i.key);
  assign swap_r  = occ_self_i && (left_i.key > dat_r.key);

  always_comb begin
    dat_nxt = dat_r;
    priority if (ctl_i.load && ld_en_i) begin
      dat_nxt.x = ld_pt_i.x_coord;
      dat_nxt.y = ld_pt_i.y_coord;
    end else if (ctl_i.shift) begin
      dat_nxt = right_i;
    end else if (ctl_i.sort) begin
      if (is_left && swap_l) begin
        dat_nxt = right_i;
      end else if (!is_left && swap_r) begin
        dat_nxt = left_i;
      end
    end else begin
      dat_nxt = dat_r;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
  end

  assign dat_o = dat_r;

endmodule

FILE: hw/rtl/spd_key.sv
module spd_key (
  input  logic                                  clk,
  input  logic                                  en_i,
  input  logic signed [spd_pkg::COORD_BITS-1:0] ref_x_i,
  input  logic signed [spd_pkg::COORD_BITS-1:0] ref_y_i,
  input  spd_pkg::cell_data_t                   dat_i,
  output spd_pkg::cell_data_t                   dat_o
);

  localparam int CW = spd_pkg::COORD_BITS;
  localparam int KW = spd_pkg::KEY_BITS;

  logic signed [CW:0] dx, dy;
  logic [CW:0]        dxa, dya;

  logic signed [CW-1:0] s1_x_r, s1_y_r;
  logic [CW-1:0]        s1_ax_r, s1_ay_r;
  logic signed [CW-1:0] s2_x_r, s2_y_r;
  logic [2*CW-1:0]      s2_sqx_r, s2_sqy_r;

  always_comb begin
    dx  = {dat_i.x[CW-1], dat_i.x} - {ref_x_i[CW-1], ref_x_i};
    dy  = {dat_i.y[CW-1], dat_i.y} - {ref_y_i[CW-1], ref_y_i};
    dxa = dx[CW] ? (~dx + 1'b1) : dx;
    dya = dy[CW] ? (~dy + 1'b1) : dy;
  end

  // two slots of the key ring: magnitude, then squares
  always_ff @(posedge clk) begin
    if (en_i) begin
      s1_x_r   <= dat_i.x;
      s1_y_r   <= dat_i.y;
      s1_ax_r  <= dxa[CW-1:0];
      s1_ay_r  <= dya[CW-1:0];
      s2_x_r   <= s1_x_r;
      s2_y_r   <= s1_y_r;
      s2_sqx_r <= s1_ax_r * s1_ax_r;
      s2_sqy_r <= s1_ay_r * s1_ay_r;
    end
  end

  always_comb begin
    dat_o.x   = s2_x_r;
    dat_o.y   = s2_y_r;
    dat_o.key = KW'(s2_sqx_r) + KW'(s2_sqy_r);
  end

endmodule

FILE: hw/rtl/spd_checker.sv
module spd_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input spd_pkg::pt_in_t  in_data,
  input logic             out_valid,
  input spd_pkg::pt_out_t out_data
);

  // results only come out of a busy run
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat outside a run");

  // the closing point starts the run
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_point) |=> busy)
    else $error("closing point did not start a run");

  a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_list) |=> !out_valid)
    else $error("result beat after end of list");

  a_trunc_const: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid)) |-> (out_data.truncated == $past(out_data.truncated)))
    else $error("truncated flag changed within a run");

endmodule

bind sort_points_by_distance_from_corner spd_checker u_spd_checker (.*);

FILE: sim/sort_points_by_distance_from_corner_tb.sv
module sort_points_by_distance_from_corner_tb;

  localparam int IDLE_LIMIT    = 4000;
  localparam int TAIL_CYCLES   = 2 * spd_pkg::MAX_POINTS + 8;
  localparam int TARGET_POINTS = 300;
  localparam int C_MAX         = (1 << (spd_pkg::COORD_BITS - 1)) - 1;
  localparam int C_MIN         = -(1 << (spd_pkg::COORD_BITS - 1));
  localparam int N_DIRECTED    = 22;

  // Mirrors the point store and emits the sorted order when a set closes.
  class dist_sort_board;
    logic signed [spd_pkg::COORD_BITS-1:0] held_x[spd_pkg::MAX_POINTS];
    logic signed [spd_pkg::COORD_BITS-1:0] held_y[spd_pkg::MAX_POINTS];
    int                                    held_cnt;
    logic signed [spd_pkg::COORD_BITS-1:0] corner_x;
    logic signed [spd_pkg::COORD_BITS-1:0] corner_y;
    bit                                    dropped;
    spd_pkg::pt_out_t                      sorted_beats[$];
    int                                    errors;

    function new();
      held_cnt = 0;
      corner_x = '0;
      corner_y = '0;
      dropped  = 1'b0;
      errors   = 0;
    endfunction

    function void note_point(spd_pkg::pt_in_t p);
      logic [spd_pkg::KEY_BITS-1:0]          dist2[spd_pkg::MAX_POINTS];
      logic signed [spd_pkg::COORD_BITS-1:0] kx, ky;
      logic [spd_pkg::KEY_BITS-1:0]          kk;
      longint                                dx, dy;
      int                                    i, j;
      spd_pkg::pt_out_t                      r;
      if (held_cnt < spd_pkg::MAX_POINTS) begin
        if (held_cnt == 0 || p.x_coord < corner_x ||
            (p.x_coord == corner_x && p.y_coord < corner_y)) begin
          corner_x = p.x_coord;
          corner_y = p.y_coord;
        end
        held_x[held_cnt] = p.x_coord;
        held_y[held_cnt] = p.y_coord;
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (!p.last_point) return;

      for (i = 0; i < held_cnt; i++) begin
        dx = held_x[i];
        dy = held_y[i];
        dx = dx - corner_x;
        dy = dy - corner_y;
        dist2[i] = spd_pkg::KEY_BITS'(dx * dx + dy * dy);
      end
      // insertion sort, strict compare keeps arrival order on equal keys
      for (j = 1; j < held_cnt; j++) begin
        kx = held_x[j];
        ky = held_y[j];
        kk = dist2[j];
        i = j;
        while (i > 0 && dist2[i-1] > kk) begin
          held_x[i] = held_x[i-1];
          held_y[i] = held_y[i-1];
          dist2[i]  = dist2[i-1];
          i--;
        end
        held_x[i] = kx;
        held_y[i] = ky;
        dist2[i]  = kk;
      end
      for (i = 0; i < held_cnt; i++) begin
        r.sorted_x    = held_x[i];
        r.sorted_y    = held_y[i];
        r.end_of_list = (i == held_cnt - 1);
        r.truncated   = dropped;
        sorted_beats  = {sorted_beats, r};
      end
      held_cnt = 0;
      dropped  = 1'b0;
    endfunction

    function void check_result(spd_pkg::pt_out_t got);
      spd_pkg::pt_out_t want;
      if (sorted_beats.size() == 0) begin
        if (errors < 10)
          $display("unexpected result beat: x=%0d y=%0d eol=%0b trunc=%0b",
                   got.sorted_x, got.sorted_y, got.end_of_list, got.truncated);
        errors++;
        return;
      end
      want = sorted_beats.pop_front();
      if (got.sorted_x !== want.sorted_x || got.sorted_y !== want.sorted_y ||
          got.end_of_list !== want.end_of_list || got.truncated !== want.truncated) begin
        if (errors < 10)
          $display(
            "mismatch: exp x=%0d y=%0d eol=%0b tr=%0b, got x=%0d y=%0d eol=%0b tr=%0b",
            want.sorted_x, want.sorted_y, want.end_of_list, want.truncated,
            got.sorted_x, got.sorted_y, got.end_of_list, got.truncated);
        errors++;
      end
    endfunction
  endclass

  logic             clk     = 1'b0;
  logic             rst_n   = 1'b0;
  logic             start   = 1'b0;
  spd_pkg::pt_in_t  in_data = '0;
  logic             busy;
  logic             out_valid;
  spd_pkg::pt_out_t out_data;

  dist_sort_board sb;
  int             idle_cycles = 0;
  int             burst_left  = 0;

  // x, y, last: extremes, reference ties, equal distances, identical points
  int dir_pts[N_DIRECTED][3] = '{
    '{-32768, -32768, 1},
    '{ 32767,  32767, 1},
    '{ 32767, -32768, 0}, '{-32768,  32767, 0}, '{-32768, -32768, 0}, '{32767, 32767, 1},
    '{5, 3, 0}, '{5, -2, 0}, '{5, 7, 0}, '{8, -2, 1},
    '{0, 0, 0}, '{0, 5, 0}, '{3, 4, 0}, '{5, 0, 0}, '{4, -3, 0}, '{3, -4, 1},
    '{2, 2, 0}, '{2, 2, 0}, '{2, 2, 1},
    '{10, 10, 0}, '{9, 9, 0}, '{-1, 20, 1}
  };

  sort_points_by_distance_from_corner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_point(in_data);
      if (out_valid) sb.check_result(out_data);
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic spd_pkg::pt_in_t mk_point(int x, int y, bit last);
    spd_pkg::pt_in_t p;
    p.x_coord    = spd_pkg::COORD_BITS'(x);
    p.y_coord    = spd_pkg::COORD_BITS'(y);
    p.last_point = last;
    return p;
  endfunction

  // mode 0: full range, 1: tight cluster for distance ties, 2: near the rails
  function automatic int pick_coord(int mode);
    case (mode)
      0:       return int'($urandom_range(C_MAX - C_MIN)) + C_MIN;
      1:       return int'($urandom_range(6)) - 3;
      default: return $urandom_range(1) ? C_MAX - int'($urandom_range(2))
                                        : C_MIN + int'($urandom_range(2));
    endcase
  endfunction

  task automatic send_point(input spd_pkg::pt_in_t p);
    start   <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int cycles);
    start   <= 1'b0;
    in_data <= spd_pkg::pt_in_t'({$urandom, 1'($urandom)});
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_paced(input spd_pkg::pt_in_t p);
    send_point(p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12, 1);
      if ($urandom_range(3) != 0) pause_sender($urandom_range(6, 1));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.sorted_beats.size() != 0);
  endtask

  initial begin
    int sent, set_len, mode, n_sets, k;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_DIRECTED; k++)
      send_paced(mk_point(dir_pts[k][0], dir_pts[k][1], dir_pts[k][2] != 0));

    // hold off until the directed sets have fully drained
    start <= 1'b0;
    wait_drained();

    sent   = 0;
    n_sets = 0;
    while (sent < TARGET_POINTS || n_sets < 2) begin
      // first a full set, then one that drops its closing point
      if (n_sets == 0)
        set_len = spd_pkg::MAX_POINTS;
      else if (n_sets == 1)
        set_len = spd_pkg::MAX_POINTS + 1;
      else if ($urandom_range(9) == 0)
        set_len = $urandom_range(spd_pkg::MAX_POINTS + 6, spd_pkg::MAX_POINTS - 4);
      else
        set_len = $urandom_range(8, 1);
      mode = $urandom_range(2);
      for (k = 0; k < set_len; k++)
        send_paced(mk_point(pick_coord(mode), pick_coord(mode), k == set_len - 1));
      sent += set_len;
      n_sets++;
    end

    start <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.sorted_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
